FILE: rtl/circle_rasterizer_assert.svh
// Assertion macros shared by the circle rasterizer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef CIRCLE_RASTERIZER_ASSERT_SVH
`define CIRCLE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CRAST_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("circle rasterizer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CRAST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("circle rasterizer assertion failed");

`endif

FILE: rtl/crast_pkg.sv
// Shared types and constants of the circle rasterizer.
// Depends on nothing; used by every rasterizer module.
package crast_pkg;

  localparam int WALK_W     = 11;
  localparam int DEC_W      = 14;
  localparam int STEP_W     = 10;
  localparam int RADIUS_W   = 10;
  localparam int PT_W       = 12;
  localparam int RECT_W     = 19;
  localparam int ORG_W      = 11;
  localparam int ZOOM_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int PIDX_W     = 3;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM     = 2'd2;

  localparam logic [ORG_W-1:0]  ORIGIN_X_RESET = 11'd300;
  localparam logic [ORG_W-1:0]  ORIGIN_Y_RESET = 11'd300;
  localparam logic [ZOOM_W-1:0] ZOOM_RESET     = 7'd25;

  localparam logic [DEC_W-1:0] DEC_INIT = 14'd3;
  localparam logic [DEC_W-1:0] DEC_KEEP = 14'd6;
  localparam logic [DEC_W-1:0] DEC_MOVE = 14'd10;

  localparam logic [STEP_W-1:0] STEP_FIRST = 10'd1;
  localparam logic [PIDX_W-1:0] LAST_POINT = 3'd7;

  typedef struct packed {
    logic [ORG_W-1:0]  origin_x;
    logic [ORG_W-1:0]  origin_y;
    logic [ZOOM_W-1:0] zoom;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: rtl/crast_front.sv
// Front end: accepts items, keeps the octant walk and issues one step record per step.
// Depends on crast_pkg.
module crast_front #(
  parameter int COORD_WIDTH = 11,
  parameter int REC_W       = 2 * COORD_WIDTH + 2 * crast_pkg::WALK_W
                              + crast_pkg::DEC_W + crast_pkg::STEP_W + 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic                                full,
  input  logic                                mode,
  input  logic signed [COORD_WIDTH-1:0]       center_x,
  input  logic signed [COORD_WIDTH-1:0]       center_y,
  input  logic [crast_pkg::RADIUS_W-1:0]      radius,
  output logic                                rec_push,
  output logic [REC_W-1:0]                    rec_data
);

  localparam int WW = crast_pkg::WALK_W;
  localparam int DW = crast_pkg::DEC_W;

  logic signed [WW-1:0]          walk_x, walk_y;
  logic [DW-1:0]                 decision_value;
  logic signed [COORD_WIDTH-1:0] centre_x_held, centre_y_held;
  logic [crast_pkg::STEP_W-1:0]  step_counter;
  logic                          active;

  logic                 accept, walking, dec_neg, done_next;
  logic signed [WW-1:0] walk_x_next, walk_y_next;
  logic [DW-1:0]        decision_next, x_ext, xy_diff, x_times4, xy_times4;

  assign accept  = push && !full;
  assign walking = active && !(walk_y < walk_x);
  assign dec_neg = decision_value[DW-1];

  always_comb begin
    x_ext       = DW'(walk_x);
    xy_diff     = DW'(walk_x) - DW'(walk_y);
    x_times4    = {x_ext[DW-3:0], 2'b00};
    xy_times4   = {xy_diff[DW-3:0], 2'b00};
    walk_x_next = walk_x + WW'(1);
    if (dec_neg) begin
      decision_next = decision_value + x_times4 + crast_pkg::DEC_KEEP;
      walk_y_next   = walk_y;
    end else begin
      decision_next = decision_value + xy_times4 + crast_pkg::DEC_MOVE;
      walk_y_next   = walk_y - WW'(1);
    end
    done_next = walk_y_next < walk_x_next;
  end

  assign rec_push = accept && (mode == crast_pkg::MODE_STEP) && walking;
  assign rec_data = {centre_x_held, centre_y_held, walk_x, walk_y,
                     decision_value, step_counter, done_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_x         <= '0;
      walk_y         <= '0;
      decision_value <= '0;
      centre_x_held  <= '0;
      centre_y_held  <= '0;
      step_counter   <= '0;
      active         <= 1'b0;
    end else if (accept) begin
      if (mode == crast_pkg::MODE_START) begin
        // Load a new circle, dropping any in progress.
        centre_x_held  <= center_x;
        centre_y_held  <= center_y;
        walk_x         <= '0;
        walk_y         <= WW'({1'b0, radius});
        decision_value <= crast_pkg::DEC_INIT - DW'({radius, 1'b0});
        step_counter   <= crast_pkg::STEP_FIRST;
        active         <= 1'b1;
      end else if (walking) begin
        walk_x         <= walk_x_next;
        walk_y         <= walk_y_next;
        decision_value <= decision_next;
        step_counter   <= step_counter + crast_pkg::STEP_W'(1);
        if (done_next) begin
          active <= 1'b0;
        end
      end else begin
        active <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/crast_queue.sv
// Short register queue of step records between the front and back ends.
// Depends on crast_pkg and circle_rasterizer_assert.svh.
`include "circle_rasterizer_assert.svh"

module crast_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [WIDTH-1:0]       push_data,
  input  logic                   pop,
  output logic [WIDTH-1:0]       head,
  output crast_pkg::q_status_t   status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head         = mem[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `CRAST_ASSERT_IMPLY(a_push_has_room, clk, rst, push, count != CNT_W'(DEPTH))
  `CRAST_ASSERT_IMPLY(a_pop_has_item, clk, rst, pop, count != '0)
  `CRAST_ASSERT_NEXT(a_count_moves, clk, rst, push != pop, count != $past(count))

endmodule

FILE: rtl/crast_back.sv
// Back end: expands each step record into eight points and maps them to screen.
// Depends on crast_pkg and circle_rasterizer_assert.svh.
`include "circle_rasterizer_assert.svh"

module crast_back #(
  parameter int COORD_WIDTH = 11,
  parameter int REC_W       = 2 * COORD_WIDTH + 2 * crast_pkg::WALK_W
                              + crast_pkg::DEC_W + crast_pkg::STEP_W + 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  crast_pkg::cfg_t                      cfg,
  input  crast_pkg::q_status_t                 qstat,
  input  logic [REC_W-1:0]                     head,
  output logic                                 rec_pop,
  input  logic                                 pop,
  output logic                                 empty,
  output logic signed [crast_pkg::PT_W-1:0]    point_x,
  output logic signed [crast_pkg::PT_W-1:0]    point_y,
  output logic signed [crast_pkg::RECT_W-1:0]  rect_left,
  output logic signed [crast_pkg::RECT_W-1:0]  rect_top,
  output logic signed [crast_pkg::RECT_W-1:0]  rect_right,
  output logic signed [crast_pkg::RECT_W-1:0]  rect_bottom,
  output logic [crast_pkg::STEP_W-1:0]         step_number,
  output logic signed [crast_pkg::DEC_W-1:0]   decision,
  output logic                                 last_of_step,
  output logic                                 circle_done
);

  localparam int WW = crast_pkg::WALK_W;
  localparam int RW = crast_pkg::RECT_W;
  localparam int PW = ((COORD_WIDTH > WW) ? COORD_WIDTH : WW) + 2;

  // Head record fields.
  logic signed [COORD_WIDTH-1:0] h_cx, h_cy;
  logic signed [WW-1:0]          h_x, h_y;
  logic [crast_pkg::DEC_W-1:0]   h_dec;
  logic [crast_pkg::STEP_W-1:0]  h_step;
  logic                          h_done;

  assign {h_cx, h_cy, h_x, h_y, h_dec, h_step, h_done} = head;

  logic                          advance, issue;
  logic [crast_pkg::PIDX_W-1:0]  pidx;
  logic signed [PW-1:0]          off_a, off_b, px_next, py_next;

  // Stage 1: logical point.
  logic                          s1_valid, s1_last, s1_done;
  logic signed [PW-1:0]          s1_px, s1_py;
  logic [crast_pkg::STEP_W-1:0]  s1_step;
  logic [crast_pkg::DEC_W-1:0]   s1_dec;
  // Stage 2: scaled offsets.
  logic                          s2_valid, s2_last, s2_done;
  logic [crast_pkg::PT_W-1:0]    s2_px, s2_py;
  logic [RW-1:0]                 s2_mx, s2_my;
  logic [crast_pkg::STEP_W-1:0]  s2_step;
  logic [crast_pkg::DEC_W-1:0]   s2_dec;
  // Output register.
  logic                          out_valid;

  logic [RW-1:0] px_wide, py_wide, zoom_wide, half_zoom, sx, sy;

  // The whole pipe holds while a result waits untaken.
  assign advance = !out_valid || pop;
  assign issue   = advance && !qstat.empty;
  assign rec_pop = issue && (pidx == crast_pkg::LAST_POINT);
  assign empty   = !out_valid;

  // Point order: bit 2 swaps the axes, bit 0 negates the first, bit 1 the second.
  always_comb begin
    off_a   = pidx[2] ? PW'(h_y) : PW'(h_x);
    off_b   = pidx[2] ? PW'(h_x) : PW'(h_y);
    px_next = PW'(h_cx) + (pidx[0] ? -off_a : off_a);
    py_next = PW'(h_cy) + (pidx[1] ? -off_b : off_b);
  end

  assign px_wide   = RW'(s1_px);
  assign py_wide   = RW'(s1_py);
  assign zoom_wide = RW'(cfg.zoom);
  assign half_zoom = RW'(cfg.zoom[crast_pkg::ZOOM_W-1:1]);
  assign sx        = RW'(cfg.origin_x) + s2_mx;
  assign sy        = RW'(cfg.origin_y) - s2_my;

  always_ff @(posedge clk) begin
    if (rst) begin
      pidx      <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      if (issue) begin
        pidx <= pidx + crast_pkg::PIDX_W'(1);
      end
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_px   <= px_next;
      s1_py   <= py_next;
      s1_step <= h_step;
      s1_dec  <= h_dec;
      s1_last <= (pidx == crast_pkg::LAST_POINT);
      s1_done <= h_done && (pidx == crast_pkg::LAST_POINT);

      s2_px   <= s1_px[crast_pkg::PT_W-1:0];
      s2_py   <= s1_py[crast_pkg::PT_W-1:0];
      s2_mx   <= px_wide * zoom_wide;
      s2_my   <= py_wide * zoom_wide;
      s2_step <= s1_step;
      s2_dec  <= s1_dec;
      s2_last <= s1_last;
      s2_done <= s1_done;

      point_x      <= s2_px;
      point_y      <= s2_py;
      rect_left    <= sx - half_zoom;
      rect_top     <= sy - half_zoom;
      rect_right   <= sx + half_zoom - RW'(1);
      rect_bottom  <= sy + half_zoom + RW'(1);
      step_number  <= s2_step;
      decision     <= s2_dec;
      last_of_step <= s2_last;
      circle_done  <= s2_done;
    end
  end

  `CRAST_ASSERT_IMPLY(a_done_on_last, clk, rst, out_valid && circle_done, last_of_step)

endmodule

FILE: rtl/circle_rasterizer.sv
// Top level of the midpoint circle rasterizer: configuration registers and wiring.
// Depends on crast_pkg, crast_front, crast_queue and crast_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------------
//  input    | push / full        | mode, center_x, center_y, radius
//  result   | empty / pop        | point_x, point_y, rect_*, step_number, decision,
//           |                    | last_of_step, circle_done
//  config   | cfg_valid/cfg_ready| cfg_index, cfg_data (cfg_ready is always high)
//
// A start item yields no result. A step item on an active circle yields eight
// results, one per cycle on the result side while records wait and results are
// taken; the back pipeline sets this rate. There is no clearing pass on reset.
// While a result waits and pop stays low the back pipeline holds; the front
// keeps taking items until QUEUE_DEPTH step records wait, then full rises.
module circle_rasterizer #(
  parameter int COORD_WIDTH = 11,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input channel
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  mode,
  input  logic signed [COORD_WIDTH-1:0]         center_x,
  input  logic signed [COORD_WIDTH-1:0]         center_y,
  input  logic [crast_pkg::RADIUS_W-1:0]        radius,
  // result channel
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [crast_pkg::PT_W-1:0]     point_x,
  output logic signed [crast_pkg::PT_W-1:0]     point_y,
  output logic signed [crast_pkg::RECT_W-1:0]   rect_left,
  output logic signed [crast_pkg::RECT_W-1:0]   rect_top,
  output logic signed [crast_pkg::RECT_W-1:0]   rect_right,
  output logic signed [crast_pkg::RECT_W-1:0]   rect_bottom,
  output logic [crast_pkg::STEP_W-1:0]          step_number,
  output logic signed [crast_pkg::DEC_W-1:0]    decision,
  output logic                                  last_of_step,
  output logic                                  circle_done,
  // configuration channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [crast_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [crast_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Step record: centre, walk position, decision, step index, done flag.
  localparam int REC_W = 2 * COORD_WIDTH + 2 * crast_pkg::WALK_W
                         + crast_pkg::DEC_W + crast_pkg::STEP_W + 1;

  crast_pkg::cfg_t      cfg;
  crast_pkg::q_status_t qstat;
  logic                 rec_push, rec_pop;
  logic [REC_W-1:0]     rec_data, rec_head;

  // Configuration registers accept a write every cycle; unknown indexes drop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x <= crast_pkg::ORIGIN_X_RESET;
      cfg.origin_y <= crast_pkg::ORIGIN_Y_RESET;
      cfg.zoom     <= crast_pkg::ZOOM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        crast_pkg::CFG_ORIGIN_X: cfg.origin_x <= cfg_data[crast_pkg::ORG_W-1:0];
        crast_pkg::CFG_ORIGIN_Y: cfg.origin_y <= cfg_data[crast_pkg::ORG_W-1:0];
        crast_pkg::CFG_ZOOM:     cfg.zoom     <= cfg_data[crast_pkg::ZOOM_W-1:0];
        default: ;
      endcase
    end
  end

  // The input side is full only when the step record queue is.
  assign full = qstat.full;

  crast_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .REC_W       (REC_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .mode     (mode),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .rec_push (rec_push),
    .rec_data (rec_data)
  );

  crast_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (rec_push),
    .push_data (rec_data),
    .pop       (rec_pop),
    .head      (rec_head),
    .status    (qstat)
  );

  crast_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .REC_W       (REC_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .qstat        (qstat),
    .head         (rec_head),
    .rec_pop      (rec_pop),
    .pop          (pop),
    .empty        (empty),
    .point_x      (point_x),
    .point_y      (point_y),
    .rect_left    (rect_left),
    .rect_top     (rect_top),
    .rect_right   (rect_right),
    .rect_bottom  (rect_bottom),
    .step_number  (step_number),
    .decision     (decision),
    .last_of_step (last_of_step),
    .circle_done  (circle_done)
  );

endmodule
